### hw/rtl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Shared types, constants and round functions for the SHA-1 digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned CntWidth   = 61;

	localparam logic [31:0] H0Init = 32'h67452301;
	localparam logic [31:0] H1Init = 32'hEFCDAB89;
	localparam logic [31:0] H2Init = 32'h98BADCFE;
	localparam logic [31:0] H3Init = 32'h10325476;
	localparam logic [31:0] H4Init = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PadMark  = 8'h80;
	localparam logic [5:0] LenStart = 6'd55 + 6'd1;
	localparam logic [5:0] LastIdx  = 6'd63;
	localparam logic [6:0] LastRnd  = 7'd79;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word0;
		logic [31:0] digest_word1;
		logic [31:0] digest_word2;
		logic [31:0] digest_word3;
		logic [31:0] digest_word4;
		logic        too_long;
	} result_t;

	// One classified message item on its way to the compression engine.
	typedef struct packed {
		logic                has_byte;
		logic                last;
		logic                ovf;
		logic [7:0]          data;
		logic [CntWidth-1:0] byte_cnt;
	} cmd_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20)      k = K0;
		else if (rnd < 7'd40) k = K1;
		else if (rnd < 7'd60) k = K2;
		else                  k = K3;
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < 7'd20)                      f = (b & c) | (~b & d);
		else if (rnd >= 7'd40 && rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
		else                                  f = b ^ c ^ d;
		return f;
	endfunction

endpackage

### hw/rtl/sha1md_stream_if.sv
// ----------------------------------------------------------------------------
// SHA-1 stream interface
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface sha1md_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/sha1md_front.sv
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts message items, tracks the byte count and the too-long flag.
// ----------------------------------------------------------------------------
module sha1md_front (
	input  logic                  clk,
	input  logic                  arst_n,
	sha1md_stream_if.sink         item_in,
	output logic                  push_valid,
	input  logic                  push_ready,
	output sha1md_pkg::cmd_t      push_cmd
);

	logic [sha1md_pkg::CntWidth-1:0] cnt_q;
	logic                            ovf_q;
	logic                            cnt_full;
	logic                            take;

	assign cnt_full = &cnt_q;

	always_comb begin
		push_cmd.has_byte = item_in.payload.byte_valid && !ovf_q && !cnt_full;
		push_cmd.last     = item_in.payload.end_of_message;
		push_cmd.ovf      = ovf_q || (item_in.payload.byte_valid && cnt_full);
		push_cmd.data     = item_in.payload.data_byte;
		push_cmd.byte_cnt = cnt_q + {{(sha1md_pkg::CntWidth-1){1'b0}}, push_cmd.has_byte};
	end

	assign push_valid    = item_in.valid;
	assign item_in.ready = push_ready;
	assign take          = item_in.valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (take) begin
			if (push_cmd.last) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				cnt_q <= push_cmd.byte_cnt;
				ovf_q <= push_cmd.ovf;
			end
		end
	end

endmodule

### hw/rtl/sha1md_queue.sv
// ----------------------------------------------------------------------------
// SHA-1 command queue
// Small FIFO between the front end and the compression engine.
// ----------------------------------------------------------------------------
module sha1md_queue #(
	parameter int unsigned DEPTH = sha1md_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  sha1md_pkg::cmd_t push_cmd,
	output logic             pop_valid,
	input  logic             pop_ready,
	output sha1md_pkg::cmd_t pop_cmd
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	sha1md_pkg::cmd_t mem_q [DEPTH];
	logic [PtrW-1:0]  wr_q, rd_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q != CntFull;
	assign pop_valid  = cnt_q != '0;
	assign pop_cmd    = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/sha1md_back.sv
// ----------------------------------------------------------------------------
// SHA-1 compression engine
// Fills the block buffer, pads, runs 80 rounds per block, reports digests.
// ----------------------------------------------------------------------------
module sha1md_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  sha1md_pkg::cmd_t pop_cmd,
	sha1md_stream_if.source  result_out
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_ROUND,
		S_ADD,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic [31:0]                     h_q [5];
	logic [31:0]                     w_q [16];
	logic [31:0]                     a_q, b_q, c_q, d_q, e_q;
	logic [5:0]                      idx_q;
	logic [6:0]                      rnd_q;
	logic                            ret_pad_q, ret_done_q;
	logic                            pad_first_q, len_q;
	logic [sha1md_pkg::CntWidth-1:0] cnt_q;
	logic                            ovf_q;
	logic                            out_v_q;
	sha1md_pkg::result_t             out_q;

	logic        take;
	logic        wr_en;
	logic [7:0]  wr_byte;
	logic        is_len;
	logic [7:0]  pad_byte;
	logic [63:0] bit_len;
	logic [31:0] t_new, w_new;
	logic        out_free;

	assign pop_ready = state_q == S_IDLE;
	assign take      = pop_valid && pop_ready;
	assign out_free  = !out_v_q || result_out.ready;

	assign bit_len  = {cnt_q, 3'b000};
	assign is_len   = !pad_first_q && (len_q || idx_q == sha1md_pkg::LenStart);

	always_comb begin
		if (pad_first_q) begin
			pad_byte = sha1md_pkg::PadMark;
		end else if (is_len) begin
			pad_byte = bit_len[{~idx_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign wr_en   = (take && pop_cmd.has_byte) || state_q == S_PAD;
	assign wr_byte = (state_q == S_PAD) ? pad_byte : pop_cmd.data;

	assign t_new = sha1md_pkg::rotl(a_q, 5) + sha1md_pkg::round_f(rnd_q, b_q, c_q, d_q)
		+ e_q + w_q[0] + sha1md_pkg::round_k(rnd_q);
	assign w_new = sha1md_pkg::rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);

	// Datapath registers: block words and working variables.
	always_ff @(posedge clk) begin
		if (state_q == S_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			a_q     <= t_new;
			b_q     <= a_q;
			c_q     <= sha1md_pkg::rotl(b_q, 30);
			d_q     <= c_q;
			e_q     <= d_q;
		end else begin
			if (wr_en) begin
				w_q[idx_q[5:2]][{~idx_q[1:0], 3'b000} +: 8] <= wr_byte;
			end
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			if (ovf_q) begin
				out_q <= '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1};
			end else begin
				out_q <= '{h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			h_q         <= '{sha1md_pkg::H0Init, sha1md_pkg::H1Init, sha1md_pkg::H2Init,
				sha1md_pkg::H3Init, sha1md_pkg::H4Init};
			idx_q       <= '0;
			rnd_q       <= '0;
			ret_pad_q   <= 1'b0;
			ret_done_q  <= 1'b0;
			pad_first_q <= 1'b0;
			len_q       <= 1'b0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_v_q <= 1'b1;
			end else if (result_out.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						cnt_q       <= pop_cmd.byte_cnt;
						ovf_q       <= pop_cmd.ovf;
						pad_first_q <= 1'b1;
						len_q       <= 1'b0;
						if (pop_cmd.has_byte) begin
							idx_q <= idx_q + 1'b1;
						end
						if (pop_cmd.has_byte && idx_q == sha1md_pkg::LastIdx) begin
							state_q    <= S_ROUND;
							rnd_q      <= '0;
							ret_pad_q  <= pop_cmd.last;
							ret_done_q <= 1'b0;
						end else if (pop_cmd.last) begin
							state_q <= pop_cmd.ovf ? S_DONE : S_PAD;
						end
					end
				end
				S_PAD: begin
					pad_first_q <= 1'b0;
					idx_q       <= idx_q + 1'b1;
					if (is_len) begin
						len_q <= 1'b1;
					end
					if (idx_q == sha1md_pkg::LastIdx) begin
						state_q    <= S_ROUND;
						rnd_q      <= '0;
						ret_pad_q  <= !is_len;
						ret_done_q <= is_len;
					end
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == sha1md_pkg::LastRnd) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					if (ret_done_q) begin
						state_q <= S_DONE;
					end else if (ret_pad_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DONE: begin
					// hold until the output register is free, then start a new message
					if (out_free) begin
						h_q     <= '{sha1md_pkg::H0Init, sha1md_pkg::H1Init,
							sha1md_pkg::H2Init, sha1md_pkg::H3Init, sha1md_pkg::H4Init};
						idx_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_out.valid   = out_v_q;
	assign result_out.payload = out_q;

endmodule

### hw/rtl/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Byte-wide SHA-1 hashing engine with a decoupled front end and compressor.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle into the buffer while the compressor is idle; it
//   takes no bytes during the round loop and chaining add of each 64-byte block.
// Completion: end of message to digest covers the padding bytes (9 to 72, none for a
//   too-long message), the round loop and add per padded block, the output register.
// Reset: arst_n clears all control state and loads the SHA-1 initial values.
module sha1_message_digest #(
	parameter int unsigned QUEUE_DEPTH = sha1md_pkg::QueueDepth
) (
	input logic             clk,
	input logic             arst_n,
	sha1md_stream_if.sink   item_in,
	sha1md_stream_if.source result_out
);

	logic             push_valid, push_ready;
	sha1md_pkg::cmd_t push_cmd;
	logic             pop_valid, pop_ready;
	sha1md_pkg::cmd_t pop_cmd;

	sha1md_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	sha1md_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	sha1md_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd),
		.result_out (result_out)
	);

endmodule
